/* rtl/rmsn_pkg.sv */
// shared types, widths and state codes for the rms normalization block
`default_nettype none
package rmsn_pkg;

  localparam int unsigned ROW_MAX_DEF = 64;
  localparam int unsigned DW    = 16;   // sample and gain width
  localparam int unsigned MAGW  = 17;   // magnitude of a 16 bit signed value
  localparam int unsigned SUMW  = 37;   // sum of squares
  localparam int unsigned EPSW  = 24;   // epsilon register
  localparam int unsigned MW    = 31;   // mean square plus epsilon
  localparam int unsigned RW    = 37;   // reciprocal root, 36 fractional bits
  localparam int unsigned RB    = 36;   // top bit of the root search
  localparam int unsigned QW    = 68;   // root times mean square
  localparam int unsigned PW    = 106;  // root squared times mean square, with headroom
  localparam int unsigned MULA  = 17;
  localparam int unsigned MULB  = 32;
  localparam int unsigned MULP  = 49;
  localparam int unsigned PRW   = 53;   // magnitude times root
  localparam int unsigned TW    = 69;   // full product plus rounding carry
  localparam logic [EPSW-1:0] EPS_RESET = 24'd168;

  typedef struct packed {
    logic signed [DW-1:0] sample;
    logic signed [DW-1:0] gain;
    logic                 row_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] normalized;
    logic                 out_last;
    logic                 overflow;
  } out_item_t;

  typedef struct packed {
    logic [DW-1:0] sample;
    logic [DW-1:0] gain;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rs_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIV, ST_MEAN, ST_ROOT, ST_RD,
    ST_MA, ST_MB, ST_MC, ST_MD, ST_RND, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RS_IDLE, RS_ADD, RS_TEST
  } rs_state_t;

  function automatic logic [MAGW-1:0] mag16(input logic [DW-1:0] v);
    mag16 = v[DW-1] ? (MAGW'(1) << DW) - MAGW'(v) : MAGW'(v);
  endfunction

endpackage
`default_nettype wire

/* rtl/rmsn_mem.sv */
// row store for samples and gains, one write and one registered read port
`default_nettype none
module rmsn_mem #(
  parameter int unsigned DEPTH = rmsn_pkg::ROW_MAX_DEF,
  parameter int unsigned AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire rmsn_pkg::entry_t    wdata,
  input  wire logic [AW-1:0]       raddr,
  output rmsn_pkg::entry_t         rdata
);

  rmsn_pkg::entry_t mem [DEPTH];
  rmsn_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/rmsn_rsqrt.sv */
// bit-serial reciprocal square root, two adder passes per result bit
`default_nettype none
module rmsn_rsqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [rmsn_pkg::MW-1:0]  m,
  output rmsn_pkg::rs_stat_t            stat,
  output logic [rmsn_pkg::RW-1:0]       rinv
);

  localparam logic [rmsn_pkg::PW-1:0] LIM = rmsn_pkg::PW'(1) << 72;

  rmsn_pkg::rs_state_t state_r, state_nxt;
  logic [rmsn_pkg::MW-1:0] m_r;
  logic [rmsn_pkg::PW-1:0] p_r, t_r;
  logic [rmsn_pkg::QW-1:0] q_r;
  logic [rmsn_pkg::RW-1:0] rinv_r;
  logic [5:0]              b_r;
  logic [rmsn_pkg::PW-1:0] c2m;
  logic                    fits;

  // candidate (q + 2^b)^2 m = q^2 m + 2^(b+1) q m + 2^2b m
  assign c2m  = t_r + (rmsn_pkg::PW'(m_r) << {b_r, 1'b0});
  assign fits = c2m <= LIM;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmsn_pkg::RS_IDLE: if (start) state_nxt = rmsn_pkg::RS_ADD;
      rmsn_pkg::RS_ADD:  state_nxt = rmsn_pkg::RS_TEST;
      rmsn_pkg::RS_TEST: begin
        state_nxt = (b_r == 6'd0) ? rmsn_pkg::RS_IDLE : rmsn_pkg::RS_ADD;
      end
      default: state_nxt = rmsn_pkg::RS_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = state_r != rmsn_pkg::RS_IDLE;
    stat.done = (state_r == rmsn_pkg::RS_TEST) && (b_r == 6'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsn_pkg::RS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rmsn_pkg::RS_IDLE: begin
        if (start) begin
          m_r    <= m;
          p_r    <= '0;
          q_r    <= '0;
          rinv_r <= '0;
          b_r    <= 6'(rmsn_pkg::RB);
        end
      end
      rmsn_pkg::RS_ADD: begin
        t_r <= p_r + (rmsn_pkg::PW'(q_r) << (7'(b_r) + 7'd1));
      end
      rmsn_pkg::RS_TEST: begin
        if (fits) begin
          p_r    <= c2m;
          q_r    <= q_r + (rmsn_pkg::QW'(m_r) << b_r);
          rinv_r <= rinv_r | (rmsn_pkg::RW'(1) << b_r);
        end
        if (b_r != 6'd0) b_r <= b_r - 6'd1;
      end
      default: ;
    endcase
  end

  assign rinv = rinv_r;

endmodule
`default_nettype wire

/* rtl/rmsnorm_forward.sv */
// rms normalization forward pass: row store, sequencer and shared multiplier
//
// Each accepted request loads one row element and its gain, one per cycle,
// while a 17x32 multiplier squares the sample into the running sum. On the
// element flagged row_last the block stops taking requests: a restoring
// divider forms the mean square, epsilon is added to it, and a
// bit-serial search finds the reciprocal root (a start step, then two adder
// passes per bit over 37 bits). Each stored element then passes through the
// same multiplier (memory read, four partial products, rounding, output),
// waiting as long as the output side stalls. Elements beyond ROW_MAX are
// dropped and every result of that row carries overflow.
`default_nettype none
module rmsnorm_forward #(
  parameter int unsigned ROW_MAX = rmsn_pkg::ROW_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire rmsn_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rmsn_pkg::out_item_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [rmsn_pkg::EPSW-1:0]  cfg_wdata
);

  localparam int unsigned CW = $clog2(ROW_MAX + 1);
  localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

  rmsn_pkg::state_t state_r, state_nxt;

  logic [rmsn_pkg::EPSW-1:0] eps_r;
  logic [rmsn_pkg::SUMW-1:0] sum_r;       // sum of squares, then quotient
  logic [CW-1:0]             cnt_r;
  logic                      drop_r;
  logic [CW-1:0]             rem_r;
  logic [5:0]                div_cnt_r;
  logic [rmsn_pkg::MW-1:0]   m_r;
  logic [AW-1:0]             k_r;
  logic [rmsn_pkg::PRW-1:0]  p_r;
  logic [rmsn_pkg::TW-1:0]   t_r;
  logic                      out_valid_r;
  rmsn_pkg::out_item_t       out_r;

  // control
  logic                      in_acc, out_acc, room, mem_we, rs_start, last_elem;
  logic [rmsn_pkg::MULA-1:0] mul_a;
  logic [rmsn_pkg::MULB-1:0] mul_b;
  logic [rmsn_pkg::MULP-1:0] mul_p;

  rmsn_pkg::entry_t          wr_ent, rd_ent;
  rmsn_pkg::rs_stat_t        rs_stat;
  logic [rmsn_pkg::RW-1:0]   rinv;

  logic [rmsn_pkg::MAGW-1:0] in_mag, ms, mg;
  logic [CW:0]               div_ext, div_diff;
  logic                      div_ge;
  logic [rmsn_pkg::MW-1:0]   mean;
  logic [rmsn_pkg::TW-1:0]   rnd;
  logic [32:0]               rmag;
  logic                      neg;
  logic [rmsn_pkg::DW-1:0]   lim, sat;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign room      = cnt_r < CW'(ROW_MAX);
  assign last_elem = (CW'(k_r) + CW'(1)) == cnt_r;

  assign in_mag = rmsn_pkg::mag16(in_data.sample);
  assign ms     = rmsn_pkg::mag16(rd_ent.sample);
  assign mg     = rmsn_pkg::mag16(rd_ent.gain);

  // restoring divide step
  assign div_ext  = {rem_r, sum_r[rmsn_pkg::SUMW-1]};
  assign div_diff = div_ext - {1'b0, cnt_r};
  assign div_ge   = div_ext >= {1'b0, cnt_r};

  // quotient is at most 2^30, so the low bits hold it
  assign mean = rmsn_pkg::MW'(sum_r[rmsn_pkg::MW-1:0]) + rmsn_pkg::MW'(eps_r);

  // round half away from zero on the magnitude, then saturate
  assign rnd  = t_r + (rmsn_pkg::TW'(1) << 35);
  assign rmag = rnd[rmsn_pkg::TW-1:36];
  assign neg  = rd_ent.sample[rmsn_pkg::DW-1] ^ rd_ent.gain[rmsn_pkg::DW-1];
  assign lim  = neg ? 16'h8000 : 16'h7fff;
  assign sat  = (rmag > 33'(lim)) ? lim : rmag[rmsn_pkg::DW-1:0];

  // shared multiplier
  assign mul_p = rmsn_pkg::MULP'(mul_a) * rmsn_pkg::MULP'(mul_b);

  assign wr_ent.sample = in_data.sample;
  assign wr_ent.gain   = in_data.gain;

  rmsn_mem #(
    .DEPTH (ROW_MAX),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wr_ent),
    .raddr (k_r),
    .rdata (rd_ent)
  );

  rmsn_rsqrt u_rsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rs_start),
    .m     (m_r),
    .stat  (rs_stat),
    .rinv  (rinv)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmsn_pkg::ST_LOAD: if (in_acc && in_data.row_last) state_nxt = rmsn_pkg::ST_DIV;
      rmsn_pkg::ST_DIV:  if (div_cnt_r == 6'd36) state_nxt = rmsn_pkg::ST_MEAN;
      rmsn_pkg::ST_MEAN: state_nxt = rmsn_pkg::ST_ROOT;
      rmsn_pkg::ST_ROOT: if (rs_stat.done) state_nxt = rmsn_pkg::ST_RD;
      rmsn_pkg::ST_RD:   state_nxt = rmsn_pkg::ST_MA;
      rmsn_pkg::ST_MA:   state_nxt = rmsn_pkg::ST_MB;
      rmsn_pkg::ST_MB:   state_nxt = rmsn_pkg::ST_MC;
      rmsn_pkg::ST_MC:   state_nxt = rmsn_pkg::ST_MD;
      rmsn_pkg::ST_MD:   state_nxt = rmsn_pkg::ST_RND;
      rmsn_pkg::ST_RND:  state_nxt = rmsn_pkg::ST_OUT;
      rmsn_pkg::ST_OUT: begin
        if (out_acc) state_nxt = last_elem ? rmsn_pkg::ST_LOAD : rmsn_pkg::ST_RD;
      end
      default: state_nxt = rmsn_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = state_r != rmsn_pkg::ST_LOAD;
    mem_we   = (state_r == rmsn_pkg::ST_LOAD) && in_valid && room;
    // start once the registered mean square is settled
    rs_start = (state_r == rmsn_pkg::ST_ROOT) && !rs_stat.busy;
    mul_a    = in_mag;
    mul_b    = rmsn_pkg::MULB'(in_mag);
    case (state_r)
      rmsn_pkg::ST_MA: begin
        mul_a = ms;
        mul_b = rinv[31:0];
      end
      rmsn_pkg::ST_MB: begin
        mul_a = ms;
        mul_b = rmsn_pkg::MULB'(rinv[rmsn_pkg::RW-1:32]);
      end
      rmsn_pkg::ST_MC: begin
        mul_a = mg;
        mul_b = p_r[31:0];
      end
      rmsn_pkg::ST_MD: begin
        mul_a = mg;
        mul_b = rmsn_pkg::MULB'(p_r[rmsn_pkg::PRW-1:32]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsn_pkg::ST_LOAD;
      eps_r       <= rmsn_pkg::EPS_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) eps_r <= cfg_wdata;
      if (out_acc) out_valid_r <= 1'b0;
      case (state_r)
        rmsn_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              sum_r <= sum_r + rmsn_pkg::SUMW'(mul_p);
              cnt_r <= cnt_r + CW'(1);
            end else begin
              drop_r <= 1'b1;
            end
            div_cnt_r <= '0;
            k_r       <= '0;
          end
        end
        rmsn_pkg::ST_DIV: begin
          sum_r     <= {sum_r[rmsn_pkg::SUMW-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 6'd1;
        end
        rmsn_pkg::ST_RND: begin
          out_valid_r <= 1'b1;
        end
        rmsn_pkg::ST_OUT: begin
          if (out_acc) begin
            if (last_elem) begin
              sum_r  <= '0;
              cnt_r  <= '0;
              drop_r <= 1'b0;
            end else begin
              k_r <= k_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state_r)
      rmsn_pkg::ST_LOAD: rem_r <= '0;
      rmsn_pkg::ST_DIV:  rem_r <= div_ge ? div_diff[CW-1:0] : div_ext[CW-1:0];
      rmsn_pkg::ST_MEAN: m_r <= (mean == '0) ? rmsn_pkg::MW'(1) : mean;
      rmsn_pkg::ST_MA:   p_r <= rmsn_pkg::PRW'(mul_p);
      rmsn_pkg::ST_MB:   p_r <= p_r + (rmsn_pkg::PRW'(mul_p) << 32);
      rmsn_pkg::ST_MC:   t_r <= rmsn_pkg::TW'(mul_p);
      rmsn_pkg::ST_MD:   t_r <= t_r + (rmsn_pkg::TW'(mul_p) << 32);
      rmsn_pkg::ST_RND: begin
        out_r.normalized <= neg ? (16'h0000 - sat) : sat;
        out_r.out_last   <= last_elem;
        out_r.overflow   <= drop_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // result held only while the sequencer waits on the output side
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == rmsn_pkg::ST_OUT)
    else $error("result valid outside output state");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ROW_MAX))
    else $error("element count beyond row limit");

  a_rs_start: assert property (@(posedge clk) disable iff (!rst_n)
    rs_start |=> rs_stat.busy)
    else $error("root unit did not start");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_r.out_last) |=> (cnt_r == '0 && sum_r == '0 && !drop_r))
    else $error("row state not cleared after last result");
`endif

endmodule
`default_nettype wire

/* tb/tb_rmsnorm_forward.sv */
// self-checking testbench for the rms normalization forward pass
`default_nettype none
module tb_rmsnorm_forward;
  timeunit 1ns;
  timeprecision 1ps;

  // longest run of cycles with no handshake before we call it hung
  localparam int unsigned HANG_LIMIT = 6000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rmsn_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  rmsn_pkg::out_item_t out_data;
  logic cfg_we;
  logic [rmsn_pkg::EPSW-1:0] cfg_wdata;

  rmsnorm_forward dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor: own copy of the row store, running sum and epsilon
  // ---------------------------------------------------------------
  logic [rmsn_pkg::DW-1:0]   row_samples [rmsn_pkg::ROW_MAX_DEF];
  logic [rmsn_pkg::DW-1:0]   row_gains [rmsn_pkg::ROW_MAX_DEF];
  logic [rmsn_pkg::SUMW-1:0] sq_sum;
  int unsigned               elem_cnt;
  logic                      row_dropped;
  logic [rmsn_pkg::EPSW-1:0] eps_reg;

  rmsn_pkg::out_item_t expected_q[$];
  int unsigned mismatches;

  function automatic logic [rmsn_pkg::MAGW-1:0] abs16(input logic [rmsn_pkg::DW-1:0] v);
    abs16 = v[rmsn_pkg::DW-1] ? rmsn_pkg::MAGW'(17'h10000 - rmsn_pkg::MAGW'(v))
                              : rmsn_pkg::MAGW'(v);
  endfunction

  // largest root with root*root*m <= 2^72, i.e. 1/sqrt(m) with 36 fraction bits
  function automatic logic [rmsn_pkg::RW-1:0] inv_root(input logic [rmsn_pkg::MW-1:0] m);
    logic [rmsn_pkg::RW-1:0] q;
    logic [rmsn_pkg::RW-1:0] c;
    logic [127:0]            p;
    q = '0;
    if (m == 0) m = 1;
    for (int b = rmsn_pkg::RB; b >= 0; b--) begin
      c = q | (rmsn_pkg::RW'(1) << b);
      p = 128'(c) * 128'(c) * 128'(m);
      if (p <= (128'(1) << 72)) q = c;
    end
    return q;
  endfunction

  // sample * root * gain, round half away from zero, saturate to q4.12
  function automatic logic [rmsn_pkg::DW-1:0] scaled(input logic [rmsn_pkg::DW-1:0] s,
                                                     input logic [rmsn_pkg::DW-1:0] g,
                                                     input logic [rmsn_pkg::RW-1:0] rinv);
    logic [127:0] t;
    logic [127:0] r;
    logic [127:0] lim;
    logic         neg;
    neg = s[rmsn_pkg::DW-1] ^ g[rmsn_pkg::DW-1];
    t = 128'(abs16(s)) * 128'(rinv) * 128'(abs16(g)) + (128'(1) << 35);
    r = t >> 36;
    lim = neg ? 128'd32768 : 128'd32767;
    if (r > lim) r = lim;
    return neg ? rmsn_pkg::DW'(17'h10000 - 17'(r)) : rmsn_pkg::DW'(r);
  endfunction

  // one accepted element request: store, accumulate, emit the row on row_last
  task automatic predict_element(input rmsn_pkg::in_item_t it);
    logic [rmsn_pkg::MW-1:0] mean_sq;
    logic [rmsn_pkg::RW-1:0] rinv;
    rmsn_pkg::out_item_t     res;
    if (elem_cnt < rmsn_pkg::ROW_MAX_DEF) begin
      row_samples[elem_cnt] = it.sample;
      row_gains[elem_cnt] = it.gain;
      sq_sum = sq_sum + rmsn_pkg::SUMW'(abs16(it.sample)) * rmsn_pkg::SUMW'(abs16(it.sample));
      elem_cnt++;
    end else begin
      row_dropped = 1'b1;
    end
    if (it.row_last) begin
      mean_sq = rmsn_pkg::MW'(sq_sum / elem_cnt) + rmsn_pkg::MW'(eps_reg);
      rinv = inv_root(mean_sq);
      for (int k = 0; k < elem_cnt; k++) begin
        res.normalized = scaled(row_samples[k], row_gains[k], rinv);
        res.out_last = (k + 1 == elem_cnt);
        res.overflow = row_dropped;
        expected_q.push_back(res);
      end
      sq_sum = '0;
      elem_cnt = 0;
      row_dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------
  int unsigned         quiet_cycles;
  rmsn_pkg::out_item_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_we) begin
        eps_reg = cfg_wdata;
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        predict_element(in_data);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.normalized !== want.normalized)
            report_mismatch("normalized", 32'(out_data.normalized), 32'(want.normalized));
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", 32'(out_data.out_last), 32'(want.out_last));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
        end
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[rmsnorm_forward] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // result side: random stall, a calm stretch, and one long hold-off
  // ---------------------------------------------------------------
  bit no_idle;
  bit hold_req;

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        // hold the output long enough that the row store fills and input stalls
        out_stall = 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = !no_idle && ($urandom_range(99) < 9);
      end
    end
  end

  // ---------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------
  task automatic send_request(input rmsn_pkg::in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(99) < 9) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
  endtask

  // epsilon may only change once the last row has fully drained
  task automatic write_epsilon(input logic [rmsn_pkg::EPSW-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [rmsn_pkg::DW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return rmsn_pkg::DW'($urandom_range(15)) - 16'd8;  // tiny, both signs
      4: return 16'h1000;
      default: return rmsn_pkg::DW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------
  typedef struct {
    bit                        is_cfg;
    logic [rmsn_pkg::EPSW-1:0] eps;
    rmsn_pkg::in_item_t        item;
    bit                        typed;
    logic [rmsn_pkg::DW-1:0]   typed_norm;
  } step_t;

  step_t directed[] = '{
    // one-element rows with the answer obvious by hand, reset epsilon
    '{0, 0, '{16'sh1000, 16'sh1000, 1'b1}, 1, 16'd4096},
    '{0, 0, '{-16'sh8000, -16'sh8000, 1'b1}, 1, 16'd32767},   // saturates high
    '{0, 0, '{-16'sh8000, 16'sh7fff, 1'b1}, 0, 16'd0},
    '{0, 0, '{16'sh7fff, -16'sh8000, 1'b1}, 0, 16'd0},
    '{0, 0, '{16'sh0000, 16'sh1000, 1'b1}, 1, 16'd0},
    // three-element row, mixed signs
    '{0, 0, '{16'sh0001, 16'sh1000, 1'b0}, 0, 16'd0},
    '{0, 0, '{-16'sh0001, -16'sh0001, 1'b0}, 0, 16'd0},
    '{0, 0, '{16'sh4000, 16'sh2000, 1'b1}, 0, 16'd0},
    // zero epsilon: all-zero row hits the zero mean square case
    '{1, 24'd0, '{16'sh0, 16'sh0, 1'b0}, 0, 16'd0},
    '{0, 0, '{16'sh0000, 16'sh7fff, 1'b1}, 1, 16'd0},
    '{0, 0, '{16'sh0001, 16'sh1000, 1'b1}, 1, 16'd4096},
    '{0, 0, '{16'sh0000, 16'sh0000, 1'b0}, 0, 16'd0},
    '{0, 0, '{16'sh0000, -16'sh8000, 1'b1}, 0, 16'd0},
    // largest epsilon
    '{1, 24'hffffff, '{16'sh0, 16'sh0, 1'b0}, 0, 16'd0},
    '{0, 0, '{16'sh1000, 16'sh1000, 1'b1}, 0, 16'd0},
    '{0, 0, '{16'sh7fff, 16'sh7fff, 1'b1}, 0, 16'd0},
    '{0, 0, '{-16'sh0800, 16'sh7fff, 1'b0}, 0, 16'd0},
    '{0, 0, '{16'sh0020, -16'sh4000, 1'b1}, 0, 16'd0},
    '{1, 24'd168, '{16'sh0, 16'sh0, 1'b0}, 0, 16'd0}
  };

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  logic [rmsn_pkg::EPSW-1:0] phase_eps[5];
  rmsn_pkg::in_item_t        it;
  int unsigned               row_len;
  int unsigned               sent;
  bit                        hold_done;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    sq_sum = '0;
    elem_cnt = 0;
    row_dropped = 1'b0;
    eps_reg = rmsn_pkg::EPS_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_epsilon(directed[i].eps);
      end else begin
        send_request(directed[i].item);
        // hand-checked rows override the predicted value
        if (directed[i].typed) begin
          wait (expected_q.size() != 0);
          expected_q[$].normalized = directed[i].typed_norm;
        end
      end
    end

    // random rows, one epsilon setting per phase
    phase_eps = '{rmsn_pkg::EPS_RESET, 24'd0, 24'hffffff,
                  rmsn_pkg::EPSW'($urandom), rmsn_pkg::EPSW'($urandom_range(4095))};
    sent = 0;
    foreach (phase_eps[p]) begin
      write_epsilon(phase_eps[p]);
      no_idle = (p == 2);
      while (sent < (p + 1) * 100) begin
        case ($urandom_range(19))
          0: row_len = $urandom_range(70, 65);   // runs past the row store
          1, 2: row_len = $urandom_range(64, 9);
          default: row_len = $urandom_range(8, 1);
        endcase
        // one long row with the output held off, so the block backs up
        if (p == 1 && !hold_done) begin
          row_len = 64;
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        for (int e = 0; e < row_len; e++) begin
          it.sample = pick_value();
          it.gain = pick_value();
          it.row_last = (e + 1 == row_len);
          send_request(it);
          sent++;
        end
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[rmsnorm_forward] OK");
    end else begin
      $display("[rmsnorm_forward] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
